// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the I2C master.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is held.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master package
// Bus phases, command codes and the beat layouts shared by the master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START    = 4'd1,
    PH_DEVW     = 4'd2,
    PH_ACK_DEVW = 4'd3,
    PH_REG      = 4'd4,
    PH_ACK_REG  = 4'd5,
    PH_DATA     = 4'd6,
    PH_ACK_DATA = 4'd7,
    PH_RESTART  = 4'd8,
    PH_DEVR     = 4'd9,
    PH_ACK_DEVR = 4'd10,
    PH_RBIT     = 4'd11,
    PH_MACK     = 4'd12,
    PH_STOP     = 4'd13
  } phase_t;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

  typedef struct packed {
    logic [1:0] func;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] wdata;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_oe;
    logic       busy_res;
    logic       data_taken;
    logic [7:0] rdata;
    logic       rdata_valid;
    logic       last_byte;
    logic       done_res;
    logic       error;
  } result_t;

endpackage

// ===== src/i2cm_core.sv =====
// ----------------------------------------------------------------------------
// I2C master tick engine
// Holds the bus sequencer state and works out one bus tick per beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cm_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  i2cm_pkg::item_t   item,
  input  logic [7:0]        ack_timeout,
  output i2cm_pkg::result_t res
);

  i2cm_pkg::phase_t phase_r, phase_nxt;
  logic [1:0] tick_r, tick_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] polls_r, polls_nxt;
  logic [6:0] dev_r, dev_nxt;
  logic [7:0] reg_r, reg_nxt;
  logic       read_r, read_nxt;
  logic       failed_r, failed_nxt;

  // state as seen by this tick, after a start command is taken
  logic             start_cmd;
  i2cm_pkg::phase_t ph_e;
  logic [1:0]       tick_e;
  logic [2:0]       bit_e;
  logic [7:0]       shift_e;
  logic [7:0]       left_e;
  logic [7:0]       polls_e;
  logic             failed_e;
  logic             latch_wdata;
  logic [7:0]       shift_cur;

  assign start_cmd = (phase_r == i2cm_pkg::PH_IDLE) &&
                     (item.func == i2cm_pkg::FUNC_WRITE || item.func == i2cm_pkg::FUNC_READ);

  always_comb begin
    ph_e     = phase_r;
    tick_e   = tick_r;
    bit_e    = bit_r;
    shift_e  = shift_r;
    left_e   = left_r;
    polls_e  = polls_r;
    failed_e = failed_r;
    dev_nxt  = dev_r;
    reg_nxt  = reg_r;
    read_nxt = read_r;
    if (start_cmd) begin
      ph_e     = i2cm_pkg::PH_START;
      tick_e   = 2'd0;
      bit_e    = 3'd0;
      shift_e  = 8'd0;
      left_e   = item.byte_count;
      polls_e  = 8'd0;
      failed_e = 1'b0;
      dev_nxt  = item.dev_addr;
      reg_nxt  = item.reg_addr;
      read_nxt = (item.func == i2cm_pkg::FUNC_READ);
    end
  end

  assign latch_wdata = (ph_e == i2cm_pkg::PH_DATA) && (bit_e == 3'd0) && (tick_e == 2'd0);
  assign shift_cur   = latch_wdata ? item.wdata : shift_e;

  // next state
  always_comb begin
    phase_nxt  = ph_e;
    tick_nxt   = tick_e;
    bit_nxt    = bit_e;
    shift_nxt  = shift_e;
    left_nxt   = left_e;
    polls_nxt  = polls_e;
    failed_nxt = failed_e;
    unique case (ph_e)
      i2cm_pkg::PH_START, i2cm_pkg::PH_RESTART: begin
        if (tick_e == 2'd3) begin
          tick_nxt  = 2'd0;
          bit_nxt   = 3'd0;
          polls_nxt = 8'd0;
          if (ph_e == i2cm_pkg::PH_START) begin
            phase_nxt = i2cm_pkg::PH_DEVW;
            shift_nxt = {dev_r & {7{~start_cmd}} | dev_nxt & {7{start_cmd}}, 1'b0};
          end else begin
            phase_nxt = i2cm_pkg::PH_DEVR;
            shift_nxt = {dev_r, 1'b1};
          end
        end else begin
          tick_nxt = tick_e + 2'd1;
        end
      end
      i2cm_pkg::PH_DEVW, i2cm_pkg::PH_REG, i2cm_pkg::PH_DATA, i2cm_pkg::PH_DEVR: begin
        shift_nxt = shift_cur;
        if (tick_e >= 2'd2) begin
          shift_nxt = {shift_cur[6:0], 1'b0};
          tick_nxt  = 2'd0;
          if (bit_e == 3'd7) begin
            bit_nxt   = 3'd0;
            polls_nxt = 8'd0;
            unique case (ph_e)
              i2cm_pkg::PH_DEVW: phase_nxt = i2cm_pkg::PH_ACK_DEVW;
              i2cm_pkg::PH_REG:  phase_nxt = i2cm_pkg::PH_ACK_REG;
              i2cm_pkg::PH_DATA: phase_nxt = i2cm_pkg::PH_ACK_DATA;
              default:           phase_nxt = i2cm_pkg::PH_ACK_DEVR;
            endcase
          end else begin
            bit_nxt = bit_e + 3'd1;
          end
        end else begin
          tick_nxt = tick_e + 2'd1;
        end
      end
      i2cm_pkg::PH_ACK_DEVW, i2cm_pkg::PH_ACK_REG, i2cm_pkg::PH_ACK_DATA,
      i2cm_pkg::PH_ACK_DEVR: begin
        priority if (tick_e == 2'd0) begin
          tick_nxt = 2'd1;
        end else if (tick_e == 2'd1) begin
          tick_nxt = 2'd2;
        end else if (!item.sda_in) begin
          // acknowledged: move on to the next part of the transfer
          tick_nxt  = 2'd0;
          bit_nxt   = 3'd0;
          polls_nxt = 8'd0;
          unique case (ph_e)
            i2cm_pkg::PH_ACK_DEVW: begin
              phase_nxt = i2cm_pkg::PH_REG;
              shift_nxt = reg_r;
            end
            i2cm_pkg::PH_ACK_REG: begin
              priority if (read_r)          phase_nxt = i2cm_pkg::PH_RESTART;
              else if (left_e == 8'd0)      phase_nxt = i2cm_pkg::PH_STOP;
              else                          phase_nxt = i2cm_pkg::PH_DATA;
            end
            i2cm_pkg::PH_ACK_DATA: begin
              left_nxt  = left_e - 8'd1;
              phase_nxt = (left_e == 8'd1) ? i2cm_pkg::PH_STOP : i2cm_pkg::PH_DATA;
            end
            default: begin
              if (left_e == 8'd0) begin
                phase_nxt = i2cm_pkg::PH_STOP;
              end else begin
                phase_nxt = i2cm_pkg::PH_RBIT;
                shift_nxt = 8'd0;
              end
            end
          endcase
        end else if (polls_e >= ack_timeout) begin
          failed_nxt = 1'b1;
          phase_nxt  = i2cm_pkg::PH_STOP;
          tick_nxt   = 2'd0;
          bit_nxt    = 3'd0;
          polls_nxt  = 8'd0;
        end else begin
          polls_nxt = polls_e + 8'd1;
        end
      end
      i2cm_pkg::PH_RBIT: begin
        if (tick_e == 2'd0) begin
          tick_nxt = 2'd1;
        end else begin
          shift_nxt = {shift_e[6:0], item.sda_in};
          tick_nxt  = 2'd0;
          if (bit_e == 3'd7) begin
            phase_nxt = i2cm_pkg::PH_MACK;
            bit_nxt   = 3'd0;
            polls_nxt = 8'd0;
          end else begin
            bit_nxt = bit_e + 3'd1;
          end
        end
      end
      i2cm_pkg::PH_MACK: begin
        if (tick_e == 2'd0) begin
          tick_nxt = 2'd1;
        end else begin
          left_nxt  = left_e - 8'd1;
          tick_nxt  = 2'd0;
          bit_nxt   = 3'd0;
          polls_nxt = 8'd0;
          if (left_e == 8'd1) begin
            phase_nxt = i2cm_pkg::PH_STOP;
          end else begin
            phase_nxt = i2cm_pkg::PH_RBIT;
            shift_nxt = 8'd0;
          end
        end
      end
      i2cm_pkg::PH_STOP: begin
        if (tick_e == 2'd3) begin
          phase_nxt = i2cm_pkg::PH_IDLE;
          tick_nxt  = 2'd0;
          bit_nxt   = 3'd0;
          polls_nxt = 8'd0;
        end else begin
          tick_nxt = tick_e + 2'd1;
        end
      end
      default: begin
        // idle, and any code outside the phase list falls back to idle
        phase_nxt = i2cm_pkg::PH_IDLE;
      end
    endcase
  end

  // line levels and flags for this tick
  always_comb begin
    logic scl, sda, oe;
    scl = 1'b1;
    sda = 1'b1;
    oe  = 1'b1;
    res = '0;
    unique case (ph_e)
      i2cm_pkg::PH_START, i2cm_pkg::PH_RESTART: begin
        scl = (tick_e == 2'd0) ? (ph_e == i2cm_pkg::PH_START) : (tick_e != 2'd3);
        sda = (tick_e < 2'd2);
      end
      i2cm_pkg::PH_DEVW, i2cm_pkg::PH_REG, i2cm_pkg::PH_DATA, i2cm_pkg::PH_DEVR: begin
        res.data_taken = latch_wdata;
        scl = (tick_e == 2'd1);
        sda = shift_cur[7];
      end
      i2cm_pkg::PH_ACK_DEVW, i2cm_pkg::PH_ACK_REG, i2cm_pkg::PH_ACK_DATA,
      i2cm_pkg::PH_ACK_DEVR: begin
        if (tick_e != 2'd0) begin
          scl = 1'b1;
          sda = 1'b0;
          oe  = 1'b0;
        end else begin
          scl = 1'b0;
        end
      end
      i2cm_pkg::PH_RBIT: begin
        oe  = 1'b0;
        sda = 1'b0;
        scl = (tick_e != 2'd0);
        if (tick_e != 2'd0 && bit_e == 3'd7) begin
          res.rdata       = {shift_e[6:0], item.sda_in};
          res.rdata_valid = 1'b1;
          res.last_byte   = (left_e == 8'd1);
        end
      end
      i2cm_pkg::PH_MACK: begin
        sda = (left_e == 8'd1);
        scl = (tick_e != 2'd0);
      end
      i2cm_pkg::PH_STOP: begin
        scl          = (tick_e >= 2'd2);
        sda          = (tick_e == 2'd3);
        res.done_res = (tick_e == 2'd3);
        res.error    = (tick_e == 2'd3) && failed_e;
      end
      default: begin
      end
    endcase
    res.scl      = scl;
    res.sda_out  = oe & sda;
    res.sda_oe   = oe;
    res.busy_res = (phase_nxt != i2cm_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= i2cm_pkg::PH_IDLE;
      tick_r   <= 2'd0;
      bit_r    <= 3'd0;
      shift_r  <= 8'd0;
      left_r   <= 8'd0;
      polls_r  <= 8'd0;
      dev_r    <= 7'd0;
      reg_r    <= 8'd0;
      read_r   <= 1'b0;
      failed_r <= 1'b0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      tick_r   <= tick_nxt;
      bit_r    <= bit_nxt;
      shift_r  <= shift_nxt;
      left_r   <= left_nxt;
      polls_r  <= polls_nxt;
      dev_r    <= dev_nxt;
      reg_r    <= reg_nxt;
      read_r   <= read_nxt;
      failed_r <= failed_nxt;
    end
  end

  `ASSERT_NEXT(a_idle_holds, clk, rst_n, fire && phase_r == i2cm_pkg::PH_IDLE && item.func != i2cm_pkg::FUNC_WRITE && item.func != i2cm_pkg::FUNC_READ, phase_r == i2cm_pkg::PH_IDLE, "idle left without a start command")
  `ASSERT_NOW(a_ack_tick, clk, rst_n, phase_r == i2cm_pkg::PH_ACK_DEVW || phase_r == i2cm_pkg::PH_ACK_REG || phase_r == i2cm_pkg::PH_ACK_DATA || phase_r == i2cm_pkg::PH_ACK_DEVR, tick_r != 2'd3, "acknowledge wait tick out of range")
  `ASSERT_NEXT(a_done_idle, clk, rst_n, fire && res.done_res, phase_r == i2cm_pkg::PH_IDLE && !$past(res.busy_res), "done without return to idle")

endmodule

// ===== src/i2c_master_burst_read_write.sv =====
// ----------------------------------------------------------------------------
// I2C master, register burst write and burst read
// Stream-driven I2C master: every input beat is one bus tick.
// ----------------------------------------------------------------------------
// Each input beat is one bus tick and yields exactly one output beat with the
// SCL/SDA levels and status flags for that tick. The block takes one beat per
// clock while the output is not stalled; a beat accepted at one clock edge is
// presented on the output from the next edge on unless the output is stalled
// (input register, then result register). Send as sda_in the SDA level seen on
// the tick that carries it; read bits and acknowledge polls are taken on the
// ticks that drive SCL high.
// The ack timeout register may only be written while no transfer is running.
`include "assert_macros.svh"

module i2c_master_burst_read_write (
  input  logic        clk,
  input  logic        rst_n,
  // func
  input  logic [1:0]  in_tuser,
  // dev_addr[6:0], reg_addr[14:7], byte_count[22:15], wdata[30:23], sda_in[31]
  input  logic [31:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // scl[0], sda_out[1], sda_oe[2], busy_res[3], data_taken[4], rdata[12:5],
  // rdata_valid[13], done_res[14], error[15]
  output logic [15:0] out_tdata,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  cfg_wdata,
  input  logic        cfg_valid,
  output logic        cfg_ready
);

  logic              in_v_r;
  i2cm_pkg::item_t   in_item_r;
  logic              out_v_r;
  i2cm_pkg::result_t out_res_r;
  i2cm_pkg::result_t res;
  logic [7:0]        ack_timeout_r;
  logic              fire;

  assign fire      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r <= i2cm_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_valid) begin
      ack_timeout_r <= cfg_wdata;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.func       <= in_tuser;
      in_item_r.dev_addr   <= in_tdata[6:0];
      in_item_r.reg_addr   <= in_tdata[14:7];
      in_item_r.byte_count <= in_tdata[22:15];
      in_item_r.wdata      <= in_tdata[30:23];
      in_item_r.sda_in     <= in_tdata[31];
    end
  end

  i2cm_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .item        (in_item_r),
    .ack_timeout (ack_timeout_r),
    .res         (res)
  );

  // result stage: hold while the consumer stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_res_r.last_byte;
  assign out_tdata  = {out_res_r.error, out_res_r.done_res, out_res_r.rdata_valid,
                       out_res_r.rdata, out_res_r.data_taken, out_res_r.busy_res,
                       out_res_r.sda_oe, out_res_r.sda_out, out_res_r.scl};

endmodule

// ===== verif/i2c_master_burst_read_write_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master burst read/write testbench
// Drives bus ticks as input beats and answers the acknowledge and read-data
// slots like a device would. An in-bench model of the master predicts the
// line levels and flags of every tick, and each output beat is checked against
// it. The ack timeout is changed between transfers, extremes included.
// ----------------------------------------------------------------------------
module i2c_master_burst_read_write_tb;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_ITEMS   = 25;

  // unused func code, behaves as a plain tick
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // scl, sda_out, sda_oe, busy_res, data_taken, rdata, rdata_valid, last_byte,
  // done_res, error
  localparam i2cm_pkg::result_t LINES_IDLE  = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00,
                                                1'b0, 1'b0, 1'b0, 1'b0};
  localparam i2cm_pkg::result_t LINES_START = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00,
                                                1'b0, 1'b0, 1'b0, 1'b0};

  typedef enum int {ACK_MIXED, ACK_PROMPT, ACK_NEVER} ack_style_t;

  typedef struct {
    i2cm_pkg::item_t   it;
    bit                typed;
    i2cm_pkg::result_t want;
    bit                run_out;
    ack_style_t        style;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [1:0]  in_tuser = '0;
  logic [31:0] in_tdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;

  i2c_master_burst_read_write u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wdata  (cfg_wdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Master model state
  i2cm_pkg::phase_t bus_ph = i2cm_pkg::PH_IDLE;
  logic [1:0] qtick = '0;
  logic [2:0] bit_no = '0;
  logic [7:0] shreg = '0;
  logic [7:0] bytes_left = '0;
  logic [7:0] polls = '0;
  logic [6:0] dev_hold = '0;
  logic [7:0] reg_hold = '0;
  logic       rd_xfer = 1'b0;
  logic       nak_fail = 1'b0;
  logic [7:0] ack_limit = i2cm_pkg::ACK_TIMEOUT_RST;

  i2cm_pkg::result_t bus_levels_q [$];
  row_t       plan [$];
  int         mismatches = 0;
  int         ack_hold = 0;
  int         burst_left = 0;
  int         idle_cycles = 0;
  int         rdy_left = 0;
  int         rdy_mode = 0;
  int         stall_cnt = 0;

  function automatic void enter_phase(i2cm_pkg::phase_t p);
    bus_ph = p;
    qtick  = '0;
    bit_no = '0;
    polls  = '0;
  endfunction

  // One bus tick of the master: returns the levels and flags of this tick.
  function automatic i2cm_pkg::result_t bus_tick(i2cm_pkg::item_t it);
    i2cm_pkg::result_t r;
    logic    scl_v, sda_v, oe_v;
    r = '0;
    scl_v = 1'b1;
    sda_v = 1'b1;
    oe_v  = 1'b1;
    if (bus_ph == i2cm_pkg::PH_IDLE &&
        (it.func == i2cm_pkg::FUNC_WRITE || it.func == i2cm_pkg::FUNC_READ)) begin
      dev_hold   = it.dev_addr;
      reg_hold   = it.reg_addr;
      bytes_left = it.byte_count;
      rd_xfer    = (it.func == i2cm_pkg::FUNC_READ);
      nak_fail   = 1'b0;
      shreg      = '0;
      enter_phase(i2cm_pkg::PH_START);
    end
    case (bus_ph)
      i2cm_pkg::PH_START, i2cm_pkg::PH_RESTART: begin
        scl_v = (qtick == 0) ? (bus_ph == i2cm_pkg::PH_START) : (qtick < 3);
        sda_v = (qtick < 2);
        if (qtick == 3) begin
          if (bus_ph == i2cm_pkg::PH_START) begin
            enter_phase(i2cm_pkg::PH_DEVW);
            shreg = {dev_hold, 1'b0};
          end else begin
            enter_phase(i2cm_pkg::PH_DEVR);
            shreg = {dev_hold, 1'b1};
          end
        end else begin
          qtick++;
        end
      end
      i2cm_pkg::PH_DEVW, i2cm_pkg::PH_REG, i2cm_pkg::PH_DATA, i2cm_pkg::PH_DEVR: begin
        if (bus_ph == i2cm_pkg::PH_DATA && bit_no == 0 && qtick == 0) begin
          shreg = it.wdata;
          r.data_taken = 1'b1;
        end
        scl_v = (qtick == 1);
        sda_v = shreg[7];
        if (qtick >= 2) begin
          shreg = shreg << 1;
          qtick = '0;
          if (bit_no == 7) enter_phase(i2cm_pkg::phase_t'(bus_ph + 4'd1));
          else bit_no++;
        end else begin
          qtick++;
        end
      end
      i2cm_pkg::PH_ACK_DEVW, i2cm_pkg::PH_ACK_REG, i2cm_pkg::PH_ACK_DATA,
      i2cm_pkg::PH_ACK_DEVR: begin
        if (qtick == 0) begin
          scl_v = 1'b0;
          qtick = 2'd1;
        end else begin
          oe_v = 1'b0;
          sda_v = 1'b0;
          if (qtick == 1) begin
            qtick = 2'd2;
          end else if (!it.sda_in) begin
            case (bus_ph)
              i2cm_pkg::PH_ACK_DEVW: begin
                enter_phase(i2cm_pkg::PH_REG);
                shreg = reg_hold;
              end
              i2cm_pkg::PH_ACK_REG: begin
                if (rd_xfer) enter_phase(i2cm_pkg::PH_RESTART);
                else if (bytes_left == 0) enter_phase(i2cm_pkg::PH_STOP);
                else enter_phase(i2cm_pkg::PH_DATA);
              end
              i2cm_pkg::PH_ACK_DATA: begin
                bytes_left--;
                if (bytes_left == 0) enter_phase(i2cm_pkg::PH_STOP);
                else enter_phase(i2cm_pkg::PH_DATA);
              end
              default: begin
                if (bytes_left == 0) begin
                  enter_phase(i2cm_pkg::PH_STOP);
                end else begin
                  enter_phase(i2cm_pkg::PH_RBIT);
                  shreg = '0;
                end
              end
            endcase
          end else if (polls >= ack_limit) begin
            nak_fail = 1'b1;
            enter_phase(i2cm_pkg::PH_STOP);
          end else begin
            polls++;
          end
        end
      end
      i2cm_pkg::PH_RBIT: begin
        oe_v  = 1'b0;
        sda_v = 1'b0;
        scl_v = (qtick != 0);
        if (qtick == 0) begin
          qtick = 2'd1;
        end else begin
          shreg = {shreg[6:0], it.sda_in};
          qtick = '0;
          if (bit_no == 7) begin
            r.rdata       = shreg;
            r.rdata_valid = 1'b1;
            r.last_byte   = (bytes_left == 1);
            enter_phase(i2cm_pkg::PH_MACK);
          end else begin
            bit_no++;
          end
        end
      end
      i2cm_pkg::PH_MACK: begin
        // NACK on the final byte, ACK on every other
        sda_v = (bytes_left == 1);
        scl_v = (qtick != 0);
        if (qtick == 0) begin
          qtick = 2'd1;
        end else begin
          bytes_left--;
          if (bytes_left == 0) begin
            enter_phase(i2cm_pkg::PH_STOP);
          end else begin
            enter_phase(i2cm_pkg::PH_RBIT);
            shreg = '0;
          end
        end
      end
      i2cm_pkg::PH_STOP: begin
        scl_v = (qtick >= 2);
        sda_v = (qtick == 3);
        if (qtick == 3) begin
          r.done_res = 1'b1;
          r.error    = nak_fail;
          enter_phase(i2cm_pkg::PH_IDLE);
        end else begin
          qtick++;
        end
      end
      default: ;
    endcase
    r.scl      = scl_v;
    r.sda_out  = oe_v ? sda_v : 1'b0;
    r.sda_oe   = oe_v;
    r.busy_res = (bus_ph != i2cm_pkg::PH_IDLE);
    return r;
  endfunction

  // Pick the next tick the way a device on the bus would answer it.
  function automatic i2cm_pkg::item_t next_tick(bit allow_cmd, ack_style_t style);
    i2cm_pkg::item_t it;
    int    pick;
    it.dev_addr = 7'($urandom);
    it.reg_addr = 8'($urandom);
    it.wdata    = 8'($urandom);
    it.sda_in   = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 90) it.byte_count = 8'($urandom_range(0, 3));
    else if (pick < 97) it.byte_count = 8'($urandom_range(4, 16));
    else it.byte_count = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (bus_ph == i2cm_pkg::PH_IDLE && allow_cmd) begin
      if (pick < 45) it.func = i2cm_pkg::FUNC_WRITE;
      else if (pick < 90) it.func = i2cm_pkg::FUNC_READ;
      else if (pick < 95) it.func = i2cm_pkg::FUNC_TICK;
      else it.func = FUNC_SPARE;
    end else if (bus_ph == i2cm_pkg::PH_IDLE) begin
      it.func = (pick < 50) ? i2cm_pkg::FUNC_TICK : FUNC_SPARE;
    end else begin
      // commands while busy must be ignored
      it.func = (pick < 5) ? 2'($urandom) : i2cm_pkg::FUNC_TICK;
    end
    if (bus_ph inside {i2cm_pkg::PH_ACK_DEVW, i2cm_pkg::PH_ACK_REG,
                       i2cm_pkg::PH_ACK_DATA, i2cm_pkg::PH_ACK_DEVR}) begin
      if (qtick == 0) begin
        pick = $urandom_range(0, 99);
        case (style)
          ACK_PROMPT: ack_hold = 0;
          ACK_NEVER:  ack_hold = 1000;
          default: begin
            if (pick < 75) ack_hold = 0;
            else if (pick < 90) ack_hold = $urandom_range(1, 4);
            else if (pick < 95) ack_hold = ack_limit;
            else ack_hold = ack_limit + 1;
          end
        endcase
      end
      it.sda_in = (polls < ack_hold);
      if (style == ACK_MIXED && $urandom_range(0, 49) == 0) it.sda_in = 1'($urandom);
    end
    return it;
  endfunction

  // Drive one beat after an optional gap, then record its expected lines.
  task automatic send(i2cm_pkg::item_t it, bit typed, i2cm_pkg::result_t want);
    i2cm_pkg::result_t pred;
    int      gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 16);
      gap = $urandom_range(0, 5);
    end
    burst_left--;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tuser  <= it.func;
    in_tdata  <= {it.sda_in, it.wdata, it.byte_count, it.reg_addr, it.dev_addr};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pred = bus_tick(it);
    bus_levels_q.push_back(typed ? want : pred);
  endtask

  // Hold the input until every predicted beat has come out.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (bus_levels_q.size() != 0) @(posedge clk);
  endtask

  task automatic finish_transfer(ack_style_t style);
    while (bus_ph != i2cm_pkg::PH_IDLE) send(next_tick(1'b0, style), 1'b0, '0);
  endtask

  task automatic write_ack_timeout(logic [7:0] value);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_wdata <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ack_limit = value;
  endtask

  task automatic run_random(int count);
    i2cm_pkg::item_t it;
    bit    was_idle;
    int    done_items;
    done_items = 0;
    while (done_items < count || bus_ph != i2cm_pkg::PH_IDLE) begin
      if ($urandom_range(0, 199) == 0) drain_results();
      it = next_tick(1'b1, ACK_MIXED);
      was_idle = (bus_ph == i2cm_pkg::PH_IDLE);
      send(it, 1'b0, '0);
      if (!was_idle || bus_ph != i2cm_pkg::PH_IDLE) done_items++;
    end
  endtask

  function automatic void add_row(logic [1:0] fn, logic [6:0] dev, logic [7:0] ra,
                                  logic [7:0] cnt, logic [7:0] wd, logic sda,
                                  bit typed, i2cm_pkg::result_t want, bit run_out,
                                  ack_style_t style);
    row_t r;
    r.it      = '{fn, dev, ra, cnt, wd, sda};
    r.typed   = typed;
    r.want    = want;
    r.run_out = run_out;
    r.style   = style;
    plan.push_back(r);
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    i2cm_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (bus_levels_q.size() == 0) begin
        $display("%0t: output beat with nothing expected, actual %0h/%0b",
                 $time, out_tdata, out_tlast);
        mismatches++;
      end else begin
        want = bus_levels_q.pop_front();
        check_field("scl", want.scl, out_tdata[0]);
        check_field("sda_out", want.sda_out, out_tdata[1]);
        check_field("sda_oe", want.sda_oe, out_tdata[2]);
        check_field("busy_res", want.busy_res, out_tdata[3]);
        check_field("data_taken", want.data_taken, out_tdata[4]);
        check_field("rdata", want.rdata, out_tdata[12:5]);
        check_field("rdata_valid", want.rdata_valid, out_tdata[13]);
        check_field("last_byte", want.last_byte, out_tlast);
        check_field("done_res", want.done_res, out_tdata[14]);
        check_field("error", want.error, out_tdata[15]);
      end
    end
  end

  // Receiver: switch between always ready, random, periodic and stall runs.
  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 3);
      rdy_left = $urandom_range(64, 400);
    end else begin
      rdy_left--;
    end
    case (rdy_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 9) < 7);
      2: out_tready <= (rdy_left % 4 != 3);
      default: begin
        if (stall_cnt > 0) begin
          stall_cnt--;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
          if ($urandom_range(0, 9) == 0) stall_cnt = $urandom_range(1, 8);
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    // idle lines after reset, and the spare func code as a plain tick
    add_row(i2cm_pkg::FUNC_TICK, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, LINES_IDLE,
            1'b0, ACK_PROMPT);
    add_row(FUNC_SPARE, 7'h7f, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1, LINES_IDLE, 1'b0,
            ACK_PROMPT);
    // write with zero bytes stops after the register acknowledge
    add_row(i2cm_pkg::FUNC_WRITE, 7'h7f, 8'hff, 8'h00, 8'hff, 1'b1, 1'b1, LINES_START,
            1'b1, ACK_PROMPT);
    add_row(i2cm_pkg::FUNC_TICK, 7'h7f, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1, LINES_IDLE,
            1'b0, ACK_PROMPT);
    add_row(i2cm_pkg::FUNC_WRITE, 7'h00, 8'h00, 8'h02, 8'ha5, 1'b0, 1'b1, LINES_START,
            1'b1, ACK_PROMPT);
    // read with zero bytes still sends the repeated start and read address
    add_row(i2cm_pkg::FUNC_READ, 7'h55, 8'h3c, 8'h00, 8'h00, 1'b0, 1'b0, '0, 1'b1,
            ACK_PROMPT);
    add_row(i2cm_pkg::FUNC_READ, 7'h7f, 8'h00, 8'h03, 8'h00, 1'b1, 1'b0, '0, 1'b1,
            ACK_PROMPT);
    // device never acknowledges: single stop, done with error
    add_row(i2cm_pkg::FUNC_WRITE, 7'h2a, 8'h81, 8'h01, 8'h5a, 1'b1, 1'b0, '0, 1'b1,
            ACK_NEVER);
    // commands while busy are ignored
    add_row(i2cm_pkg::FUNC_WRITE, 7'h11, 8'h22, 8'h01, 8'h33, 1'b0, 1'b0, '0, 1'b0,
            ACK_PROMPT);
    add_row(i2cm_pkg::FUNC_READ, 7'h7f, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0, '0, 1'b0,
            ACK_PROMPT);
    add_row(i2cm_pkg::FUNC_WRITE, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '0, 1'b0,
            ACK_PROMPT);
    add_row(FUNC_SPARE, 7'h7f, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0, '0, 1'b1, ACK_PROMPT);
    add_row(i2cm_pkg::FUNC_READ, 7'h40, 8'h7e, 8'h01, 8'h00, 1'b1, 1'b0, '0, 1'b1,
            ACK_MIXED);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      send(plan[i].it, plan[i].typed, plan[i].want);
      if (plan[i].run_out) finish_transfer(plan[i].style);
    end

    write_ack_timeout(8'd0);
    run_random(RANDOM_ITEMS);
    write_ack_timeout(8'd255);
    run_random(RANDOM_ITEMS);
    write_ack_timeout(8'd2);
    run_random(RANDOM_ITEMS);
    write_ack_timeout(8'($urandom_range(1, 254)));
    run_random(RANDOM_ITEMS);

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/i2cm_pkg.sv
src/i2cm_core.sv
src/i2c_master_burst_read_write.sv
verif/i2c_master_burst_read_write_tb.sv
